@@ rtl/tcce_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console character engine package
// Screen geometry, character codes, register indexes, sequencer states and
// the item types that travel on the input and result channels.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int MOVE_COUNT = CELL_COUNT - COLUMNS;
  localparam int LAST_CELL  = CELL_COUNT - 1;

  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int ADDR_W = $clog2(CELL_COUNT);

  // Character codes and cell defaults.
  localparam logic [7:0] CH_BS       = 8'd8;
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_FF       = 8'd12;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_PRINT_LO = 8'd32;
  localparam logic [7:0] CH_PRINT_HI = 8'd126;
  localparam logic [7:0] CH_BLANK    = 8'd32;
  localparam logic [7:0] RESET_COLOR = 8'd15;
  localparam int         TAB_STOP    = 8;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ON  = 8'd1;

  // Item kinds.
  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR,
    ST_DONE
  } tcce_state_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
  } tcce_in_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic [10:0] cursor_location;
  } tcce_out_t;

endpackage

@@ rtl/text_console_char_engine.sv @@
// ----------------------------------------------------------------------------
// Text console character engine
// Keeps a character screen with a cursor, runs console control codes on it
// and returns screen cells on request.
// ----------------------------------------------------------------------------
// Usage:
//   An input beat (in_valid_i high, in_stall_o low) carries either a character
//   to put on the screen or a cell address to read. Every input beat yields
//   exactly one result beat with the cell read (zero for a put), the cursor
//   row and column after the step and the shown cursor location.
//   A plain character is decoded and its cell written in the EXEC state; a
//   read starts the registered memory read there and takes its data in READ;
//   the DONE state forms the result. The screen memory has a single write
//   port, so a scroll walks the whole screen through it: it moves the rows
//   up one cell at a time and then blanks the last row. A form feed clears
//   the whole screen one cell at a time. After reset the block fills the
//   screen with blanks in the reset color; in_stall_o stays high meanwhile,
//   while configuration writes are taken at any time.
//   The result sits in an output register. If the receiver stalls, the next
//   item can still be accepted and worked on; it waits in its final step
//   until the output register frees.
// ----------------------------------------------------------------------------
module text_console_char_engine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  tcce_pkg::tcce_in_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tcce_pkg::tcce_out_t                out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [7:0]                         cfg_data_i
);

  localparam int AW = tcce_pkg::ADDR_W;
  localparam int CW = tcce_pkg::COL_W;
  localparam int RW = tcce_pkg::ROW_W;

  tcce_pkg::tcce_state_e state_q, state_d;

  logic [CW-1:0]   col_q, col_d;
  logic [RW-1:0]   row_q, row_d;
  logic [AW-1:0]   cnt_q, cnt_d;
  logic            pend_q, pend_d;
  logic [AW-1:0]   pend_addr_q, pend_addr_d;
  logic [10:0]     shown_q, shown_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      color_q;
  logic            cursor_on_q;

  tcce_pkg::tcce_in_t  in_q, in_d;
  tcce_pkg::tcce_out_t out_data_q, out_data_d;
  logic [15:0]         data_q, data_d;

  // Screen memory ports.
  logic [15:0] screen_mem_q [tcce_pkg::CELL_COUNT];
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0] mem_wd;
  logic        mem_re;
  logic [AW-1:0] mem_ra;
  logic [15:0] rd_data_q;

  // Linear index of the cursor, shared by cell writes and the shown cursor.
  logic [AW-1:0] lin_addr;
  logic          in_beat;
  logic          out_free;

  assign lin_addr = AW'(row_q) * AW'(tcce_pkg::COLUMNS) + AW'(col_q);
  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != tcce_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Sequencer: next state, cursor update and memory port control.
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    shown_d     = shown_q;
    in_d        = in_q;
    data_d      = data_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_wa      = cnt_q;
    mem_wd      = {color_q, tcce_pkg::CH_BLANK};
    mem_re      = 1'b0;
    mem_ra      = AW'(in_q.cell_address);

    case (state_q)
      tcce_pkg::ST_INIT: begin
        // Power-up fill always uses the reset color.
        mem_we = 1'b1;
        mem_wd = {tcce_pkg::RESET_COLOR, tcce_pkg::CH_BLANK};
        cnt_d  = cnt_q + AW'(1);
        if (cnt_q == AW'(tcce_pkg::LAST_CELL)) begin
          cnt_d   = '0;
          state_d = tcce_pkg::ST_IDLE;
        end
      end

      tcce_pkg::ST_IDLE: begin
        if (in_beat) begin
          in_d    = in_data_i;
          state_d = tcce_pkg::ST_EXEC;
        end
      end

      tcce_pkg::ST_EXEC: begin
        data_d  = '0;
        state_d = tcce_pkg::ST_DONE;
        if (in_q.kind == tcce_pkg::KIND_READ) begin
          if (32'(in_q.cell_address) < tcce_pkg::CELL_COUNT) begin
            mem_re  = 1'b1;
            state_d = tcce_pkg::ST_READ;
          end
        end else begin
          case (in_q.char_code)
            tcce_pkg::CH_BS: begin
              if (col_q != '0) begin
                col_d  = col_q - CW'(1);
                mem_we = 1'b1;
                mem_wa = lin_addr - AW'(1);
              end
            end
            tcce_pkg::CH_TAB: begin
              col_d = (col_q & ~CW'(tcce_pkg::TAB_STOP - 1)) + CW'(tcce_pkg::TAB_STOP);
            end
            tcce_pkg::CH_LF: begin
              col_d = '0;
              row_d = row_q + RW'(1);
            end
            tcce_pkg::CH_FF: begin
              col_d = '0;
              row_d = '0;
            end
            tcce_pkg::CH_CR: begin
              col_d = '0;
            end
            default: begin
              if (in_q.char_code inside {[tcce_pkg::CH_PRINT_LO:tcce_pkg::CH_PRINT_HI]}) begin
                mem_we = 1'b1;
                mem_wa = lin_addr;
                mem_wd = {color_q, in_q.char_code};
                col_d  = col_q + CW'(1);
              end
            end
          endcase

          if (in_q.char_code == tcce_pkg::CH_FF) begin
            cnt_d   = '0;
            state_d = tcce_pkg::ST_CLEAR;
          end else begin
            // Line wrap, then scroll when the cursor falls off the bottom.
            if (col_d >= CW'(tcce_pkg::COLUMNS)) begin
              col_d = '0;
              row_d = row_d + RW'(1);
            end
            if (row_d >= RW'(tcce_pkg::ROWS)) begin
              row_d   = row_d - RW'(1);
              cnt_d   = '0;
              state_d = tcce_pkg::ST_SCROLL;
            end
          end
        end
      end

      tcce_pkg::ST_READ: begin
        data_d  = rd_data_q;
        state_d = tcce_pkg::ST_DONE;
      end

      tcce_pkg::ST_SCROLL: begin
        // Read one row down, write the previous read to its cell one row up.
        mem_we = pend_q;
        mem_wa = pend_addr_q;
        mem_wd = rd_data_q;
        if (cnt_q == AW'(tcce_pkg::MOVE_COUNT)) begin
          state_d = tcce_pkg::ST_BLANK;
        end else begin
          mem_re      = 1'b1;
          mem_ra      = cnt_q + AW'(tcce_pkg::COLUMNS);
          pend_d      = 1'b1;
          pend_addr_d = cnt_q;
          cnt_d       = cnt_q + AW'(1);
        end
      end

      tcce_pkg::ST_BLANK: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + AW'(1);
        if (cnt_q == AW'(tcce_pkg::LAST_CELL)) begin
          cnt_d   = '0;
          state_d = tcce_pkg::ST_DONE;
        end
      end

      tcce_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + AW'(1);
        if (cnt_q == AW'(tcce_pkg::LAST_CELL)) begin
          cnt_d   = '0;
          state_d = tcce_pkg::ST_DONE;
        end
      end

      tcce_pkg::ST_DONE: begin
        if (out_free) begin
          if (cursor_on_q) begin
            shown_d = 11'(lin_addr);
          end
          out_data_d.cell_data       = data_q;
          out_data_d.cursor_row      = 5'(row_q);
          out_data_d.cursor_column   = 7'(col_q);
          out_data_d.cursor_location = cursor_on_q ? 11'(lin_addr) : shown_q;
          out_valid_d = 1'b1;
          state_d     = tcce_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tcce_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcce_pkg::ST_INIT;
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      shown_q     <= '0;
      out_valid_q <= 1'b0;
      color_q     <= tcce_pkg::RESET_COLOR;
      cursor_on_q <= 1'b1;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      shown_q     <= shown_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == tcce_pkg::CFG_TEXT_COLOR) begin
          color_q <= cfg_data_i;
        end else if (cfg_index_i == tcce_pkg::CFG_CURSOR_ON) begin
          cursor_on_q <= cfg_data_i[0];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    in_q        <= in_d;
    data_q      <= data_d;
    pend_addr_q <= pend_addr_d;
    out_data_q  <= out_data_d;
  end

  // Screen memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= screen_mem_q[mem_ra];
    end
  end

  // A result never reports a cursor off the screen.
  a_cursor_on_screen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_data_o.cursor_row) < tcce_pkg::ROWS) &&
                    (32'(out_data_o.cursor_column) < tcce_pkg::COLUMNS))
    else $error("cursor outside the screen");

  // Every memory write lands inside the screen.
  a_write_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(mem_wa) < tcce_pkg::CELL_COUNT))
    else $error("screen write out of range");

  // An accepted item is decoded in the next cycle.
  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == tcce_pkg::ST_EXEC))
    else $error("accepted item not decoded");

endmodule
